// ----- rtl/core/ucwp_pkg.sv -----
// Package for the utility cache way partitioner.
// Holds sizes, status and register codes, and the structs between modules.
// No dependencies.
package ucwp_pkg;

	localparam int THREADS      = 4;
	localparam int MAX_WAYS     = 16;
	localparam int COUNTER_BITS = 32;

	localparam int TH_W    = 2;
	localparam int POS_W   = 4;
	localparam int ADDR_W  = TH_W + POS_W;
	localparam int DEPTH   = THREADS * MAX_WAYS;
	localparam int WAY_W   = 5;
	localparam int SUM_W   = COUNTER_BITS + POS_W;
	localparam int PROD_W  = SUM_W + WAY_W;
	localparam int IDX_W   = ADDR_W + 1;
	localparam int USED_W  = 21;
	localparam int SETS_W  = 17;
	localparam int MASK_W  = 4;
	localparam int CAP_W   = SETS_W + WAY_W;
	localparam int CMP_W   = CAP_W + 7;
	localparam int CNT_W   = 3;

	typedef logic [1:0] status_t;
	localparam status_t ST_PART = 2'd0;
	localparam status_t ST_COLD = 2'd1;
	localparam status_t ST_MANY = 2'd2;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MASK = 2'd0;
	localparam cfg_idx_t CFG_SETS = 2'd1;
	localparam cfg_idx_t CFG_WAYS = 2'd2;

	localparam logic FUNC_HIT    = 1'b0;
	localparam logic FUNC_REPART = 1'b1;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [SETS_W-1:0] sets;
		logic [WAY_W-1:0]  ways;
	} cfg_t;

	typedef struct packed {
		logic                    we;
		logic [ADDR_W-1:0]       waddr;
		logic [COUNTER_BITS-1:0] wdata;
		logic [ADDR_W-1:0]       raddr;
	} mem_req_t;

endpackage

// ----- rtl/core/ucwp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ucwp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/ucwp_seq.sv -----
// Sequencer of the way partitioner: RAM clear, hit counting, warm check, lookahead, halving, emit.
// Depends on ucwp_pkg; drives the hit counter RAM through a mem_req_t.
module ucwp_seq import ucwp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    func,
	input  logic [TH_W-1:0]         thread,
	input  logic [POS_W-1:0]        position,
	input  logic [USED_W-1:0]       used_lines,
	output mem_req_t                mem,
	input  logic [COUNTER_BITS-1:0] rdata,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [TH_W-1:0]         thread_out,
	output logic [WAY_W-1:0]        ways,
	output status_t                 status,
	output logic                    last
);

	typedef enum logic [14:0] {
		S_CLEAR      = 15'h0001,
		S_IDLE       = 15'h0002,
		S_HIT_WR     = 15'h0004,
		S_CHK_PROD   = 15'h0008,
		S_CHK_CMP    = 15'h0010,
		S_SKIP       = 15'h0020,
		S_ROUND      = 15'h0040,
		S_THREAD     = 15'h0080,
		S_STEP_RD    = 15'h0100,
		S_STEP_ACC   = 15'h0200,
		S_STEP_CMP   = 15'h0400,
		S_THREAD_END = 15'h0800,
		S_ROUND_END  = 15'h1000,
		S_HALVE      = 15'h2000,
		S_EMIT       = 15'h4000
	} state_t;

	localparam logic [TH_W-1:0] T_LAST = TH_W'(THREADS - 1);
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

	state_t                  state_q;
	logic [IDX_W-1:0]        idx_q;
	logic [ADDR_W-1:0]       haddr_q;
	logic [USED_W-1:0]       used_q;
	logic [CAP_W-1:0]        prod_q;
	status_t                 skip_q;
	logic [WAY_W-1:0]        assigned_q [THREADS];
	logic [WAY_W-1:0]        balance_q;
	logic [TH_W-1:0]         t_q;
	logic [WAY_W-1:0]        i_q;
	logic                    p_ok_q;
	logic [SUM_W-1:0]        s_q;
	logic [SUM_W-1:0]        ms_q;
	logic [WAY_W-1:0]        mn_q;
	logic [WAY_W-1:0]        req_q;
	logic                    win_ok_q;
	logic [TH_W-1:0]         win_q;
	logic [SUM_W-1:0]        ws_q;
	logic [WAY_W-1:0]        wn_q;
	logic [WAY_W-1:0]        wreq_q;
	logic                    out_valid_q;
	logic [TH_W-1:0]         thread_out_q;
	logic [WAY_W-1:0]        ways_q;
	status_t                 status_q;
	logic                    last_q;

	logic [WAY_W-1:0]        a_eff;
	logic [CNT_W-1:0]        n_cnt;
	logic [WAY_W-1:0]        p;
	logic [PROD_W-1:0]       step_lhs, step_rhs, win_lhs, win_rhs;
	logic [CMP_W-1:0]        need, have;
	logic                    out_free;
	logic                    out_load;

	assign a_eff    = (cfg.ways > WAY_W'(MAX_WAYS)) ? WAY_W'(MAX_WAYS) : cfg.ways;
	assign n_cnt    = CNT_W'($countones(cfg.mask));
	assign p        = assigned_q[t_q] + i_q - WAY_W'(1);
	assign step_lhs = PROD_W'(s_q) * PROD_W'(mn_q);
	assign step_rhs = PROD_W'(ms_q) * PROD_W'(i_q);
	assign win_lhs  = PROD_W'(ms_q) * PROD_W'(wn_q);
	assign win_rhs  = PROD_W'(ws_q) * PROD_W'(mn_q);
	// cold when 100 * used < 99 * sets * ways
	assign have     = CMP_W'(used_q) * CMP_W'(100);
	assign need     = CMP_W'(prod_q) * CMP_W'(99);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free && (state_q == S_SKIP || state_q == S_EMIT);

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign thread_out = thread_out_q;
	assign ways       = ways_q;
	assign status     = status_q;
	assign last       = last_q;

	always_comb begin
		mem       = '0;
		mem.raddr = {thread, position};
		unique case (state_q)
			S_CLEAR: begin
				mem.we    = 1'b1;
				mem.waddr = idx_q[ADDR_W-1:0];
			end
			S_HIT_WR: begin
				mem.we    = 1'b1;
				mem.waddr = haddr_q;
				mem.wdata = (rdata == CNT_MAX) ? rdata : rdata + COUNTER_BITS'(1);
			end
			S_STEP_RD: begin
				mem.raddr = {t_q, p[POS_W-1:0]};
			end
			S_HALVE: begin
				mem.raddr = idx_q[ADDR_W-1:0];
				mem.we    = (idx_q != '0);
				mem.waddr = idx_q[ADDR_W-1:0] - ADDR_W'(1);
				mem.wdata = rdata >> 1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			idx_q        <= '0;
			haddr_q      <= '0;
			used_q       <= '0;
			prod_q       <= '0;
			skip_q       <= ST_PART;
			for (int k = 0; k < THREADS; k++) begin
				assigned_q[k] <= '0;
			end
			balance_q    <= '0;
			t_q          <= '0;
			i_q          <= '0;
			p_ok_q       <= 1'b0;
			s_q          <= '0;
			ms_q         <= '0;
			mn_q         <= '0;
			req_q        <= '0;
			win_ok_q     <= 1'b0;
			win_q        <= '0;
			ws_q         <= '0;
			wn_q         <= '0;
			wreq_q       <= '0;
			out_valid_q  <= 1'b0;
			thread_out_q <= '0;
			ways_q       <= '0;
			status_q     <= ST_PART;
			last_q       <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == IDX_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (func == FUNC_HIT) begin
							haddr_q <= {thread, position};
							state_q <= S_HIT_WR;
						end else begin
							used_q  <= used_lines;
							state_q <= S_CHK_PROD;
						end
					end
				end
				S_HIT_WR: begin
					state_q <= S_IDLE;
				end
				S_CHK_PROD: begin
					prod_q  <= CAP_W'(cfg.sets) * CAP_W'(a_eff);
					state_q <= S_CHK_CMP;
				end
				S_CHK_CMP: begin
					if (have < need) begin
						skip_q  <= ST_COLD;
						state_q <= S_SKIP;
					end else if (WAY_W'(n_cnt) > a_eff) begin
						skip_q  <= ST_MANY;
						state_q <= S_SKIP;
					end else begin
						for (int k = 0; k < THREADS; k++) begin
							if (cfg.mask[k]) begin
								assigned_q[k] <= WAY_W'(1);
							end
						end
						balance_q <= a_eff - WAY_W'(n_cnt);
						state_q   <= S_ROUND;
					end
				end
				S_SKIP: begin
					if (out_free) begin
						thread_out_q <= '0;
						ways_q       <= '0;
						status_q     <= skip_q;
						last_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_ROUND: begin
					if (balance_q == '0) begin
						idx_q   <= '0;
						state_q <= S_HALVE;
					end else begin
						win_ok_q <= 1'b0;
						t_q      <= '0;
						state_q  <= S_THREAD;
					end
				end
				S_THREAD: begin
					if (cfg.mask[t_q]) begin
						s_q     <= '0;
						ms_q    <= '0;
						mn_q    <= WAY_W'(1);
						req_q   <= '0;
						i_q     <= WAY_W'(1);
						state_q <= S_STEP_RD;
					end else if (t_q == T_LAST) begin
						state_q <= S_ROUND_END;
					end else begin
						t_q <= t_q + TH_W'(1);
					end
				end
				S_STEP_RD: begin
					p_ok_q  <= (p < WAY_W'(MAX_WAYS));
					state_q <= S_STEP_ACC;
				end
				S_STEP_ACC: begin
					if (p_ok_q) begin
						s_q <= s_q + SUM_W'(rdata);
					end
					state_q <= S_STEP_CMP;
				end
				S_STEP_CMP: begin
					if (step_lhs > step_rhs) begin
						ms_q  <= s_q;
						mn_q  <= i_q;
						req_q <= i_q;
					end
					if (i_q == balance_q) begin
						state_q <= S_THREAD_END;
					end else begin
						i_q     <= i_q + WAY_W'(1);
						state_q <= S_STEP_RD;
					end
				end
				S_THREAD_END: begin
					// strict compare keeps the lowest index on a tie
					if (!win_ok_q || (win_lhs > win_rhs)) begin
						win_ok_q <= 1'b1;
						win_q    <= t_q;
						ws_q     <= ms_q;
						wn_q     <= mn_q;
						wreq_q   <= req_q;
					end
					if (t_q == T_LAST) begin
						state_q <= S_ROUND_END;
					end else begin
						t_q     <= t_q + TH_W'(1);
						state_q <= S_THREAD;
					end
				end
				S_ROUND_END: begin
					if (!win_ok_q || wreq_q == '0) begin
						idx_q   <= '0;
						state_q <= S_HALVE;
					end else begin
						assigned_q[win_q] <= assigned_q[win_q] + wreq_q;
						balance_q         <= balance_q - wreq_q;
						state_q           <= S_ROUND;
					end
				end
				S_HALVE: begin
					if (idx_q == IDX_W'(DEPTH)) begin
						t_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						thread_out_q <= t_q;
						ways_q       <= assigned_q[t_q];
						status_q     <= ST_PART;
						last_q       <= (t_q == T_LAST);
						if (t_q == T_LAST) begin
							state_q <= S_IDLE;
						end else begin
							t_q <= t_q + TH_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/utility_cache_way_partitioner_core.sv -----
// Top level of the utility cache way partitioner.
// Depends on ucwp_pkg, ucwp_ram and ucwp_seq.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one beat per item: func 0 is a
//    hit event (thread, position), func 1 a repartition request (used_lines).
//  - Output channel (out_valid / out_stall) returns result beats from one
//    output register; a repartition yields one skip beat or one beat per
//    thread, the final beat marked by last. Hit events return nothing.
//  - Configuration channel (cfg_valid / cfg_ready, always ready) writes
//    reachable_mask, set_count or ways_in_use by cfg_index; write only idle.
//  - Sequencing: a hit event reads its counter and writes it back to the
//    counter RAM. A repartition runs the warm check, then per lookahead round
//    a read, accumulate and compare for each evaluated way step of each
//    reachable thread, then halves all 64 counters, then emits one beat per
//    cycle while out_stall allows. The counter RAM has a single read port.
//  - Reset: counters and allocations clear; a clearing pass zeroes all 64
//    words of the counter RAM, during which in_stall stays high.
//  - A stalled output holds its beat; the sequencer waits for the output
//    register before loading the next beat, and a new item may be taken while
//    the last beat is still held.
module utility_cache_way_partitioner_core import ucwp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  cfg_idx_t            cfg_index,
	input  logic [SETS_W-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                func,
	input  logic [TH_W-1:0]     thread,
	input  logic [POS_W-1:0]    position,
	input  logic [USED_W-1:0]   used_lines,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [TH_W-1:0]     thread_out,
	output logic [WAY_W-1:0]    ways,
	output status_t             status,
	output logic                last
);

	cfg_t                    cfg_q;
	mem_req_t                mem;
	logic [COUNTER_BITS-1:0] rdata;

	assign cfg_ready = 1'b1;

	// Hold configuration; index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mask <= '0;
			cfg_q.sets <= SETS_W'(1024);
			cfg_q.ways <= WAY_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MASK: cfg_q.mask <= cfg_data[MASK_W-1:0];
				CFG_SETS: cfg_q.sets <= cfg_data;
				CFG_WAYS: cfg_q.ways <= cfg_data[WAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Hit counters, one word per thread and stack position.
	ucwp_ram #(
		.WIDTH (COUNTER_BITS),
		.DEPTH (DEPTH)
	) u_cnt_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	ucwp_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.thread     (thread),
		.position   (position),
		.used_lines (used_lines),
		.mem        (mem),
		.rdata      (rdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.thread_out (thread_out),
		.ways       (ways),
		.status     (status),
		.last       (last)
	);

	// No counter write while an item can be taken.
	a_no_wr_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		mem.we |-> in_stall)
		else $error("counter write while input open");

	// A skip beat always ends its run.
	a_skip_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_PART) |-> last)
		else $error("skip beat without last");

	// Every accepted item raises in_stall in the cycle after it is taken.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("sequencer took two items back to back");

endmodule
